FILE: rtl/srsg_pkg.sv
// Package: shared constants, types and helpers of the staged ramp setpoint generator.
package srsg_pkg;

  // Data widths fixed by the item fields
  localparam int ElapsedW = 10;
  localparam int LevelW   = 16;
  localparam int UsedW    = 7;
  localparam int DurW     = 16;
  localparam int TgtW     = 32;
  localparam int StageW   = 2;
  localparam int RatioW   = 17;
  localparam int TimeSumW = DurW + 1;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = TgtW;

  // Behavior constants
  localparam logic [ElapsedW-1:0] MAX_STEP_MS     = ElapsedW'(100);
  localparam int                  LEVEL_FRAC_BITS = 15;
  localparam logic [DurW-1:0]     DEF_STAGE_MS    = DurW'(4000);
  localparam logic [DurW-1:0]     DEF_TRANS_MS    = DurW'(1000);
  localparam logic [TgtW-1:0]     DEF_TGT0        = 32'h8000_8000;
  localparam logic [TgtW-1:0]     DEF_TGT1        = 32'h5333_8000;
  localparam logic [TgtW-1:0]     DEF_TGT2        = 32'h8000_8000;
  localparam logic [TgtW-1:0]     DEF_TGT3        = 32'h8000_5333;
  localparam logic [LevelW-1:0]   LEVEL_ONE       = LevelW'(1) << LEVEL_FRAC_BITS;
  localparam logic [RatioW-1:0]   RATIO_ONE       = RatioW'(1) << 16;

  // Product of a signed level difference and an unsigned ratio
  localparam int DiffW = LevelW + 1;
  localparam int ProdW = DiffW + RatioW + 1;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_STAGE_DUR = 3'd0,
    REG_TRANS_DUR = 3'd1,
    REG_TGT0      = 3'd2,
    REG_TGT1      = 3'd3,
    REG_TGT2      = 3'd4,
    REG_TGT3      = 3'd5
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_DIVT = 9'b000000010,
    ST_UPD  = 9'b000000100,
    ST_CUR  = 9'b000001000,
    ST_PRV  = 9'b000010000,
    ST_DIVR = 9'b000100000,
    ST_MULL = 9'b001000000,
    ST_MULR = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  // Limit a target half to 1.0
  function automatic logic [LevelW-1:0] clamp_half(input logic [LevelW-1:0] half);
    clamp_half = (half > LEVEL_ONE) ? LEVEL_ONE : half;
  endfunction

  // prev + floor(prod / 2^16), kept to the level width
  function automatic logic [LevelW-1:0] ramp_level(input logic [LevelW-1:0] prev,
                                                   input logic signed [ProdW-1:0] prod);
    logic signed [ProdW-1:0] step;
    logic signed [ProdW-1:0] sum;
    step = prod >>> 16;
    sum  = $signed({{(ProdW-LevelW){1'b0}}, prev}) + step;
    ramp_level = sum[LevelW-1:0];
  endfunction

endpackage

FILE: rtl/srsg_tick_if.sv
// Interface: tick request channel carrying elapsed milliseconds.
interface srsg_tick_if
  import srsg_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [ElapsedW-1:0] elapsed_ms;

  modport source (output valid, output elapsed_ms, input ready);
  modport sink   (input valid, input elapsed_ms, output ready);
endinterface

FILE: rtl/srsg_level_if.sv
// Interface: level request channel carrying left/right levels and used time.
interface srsg_level_if
  import srsg_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] left_level;
  logic [LevelW-1:0] right_level;
  logic [UsedW-1:0]  used_ms;

  modport source (output valid, output left_level, output right_level, output used_ms,
                  input ready);
  modport sink   (input valid, input left_level, input right_level, input used_ms,
                  output ready);
endinterface

FILE: rtl/staged_ramp_setpoint_generator.sv
// Top level: staged ramp setpoint generator with a shared subtractor and multiplier.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+--------------------------------------
//   tick     | in  | valid/ready      | elapsed_ms[9:0]
//   level    | out | valid/ready      | left_level[15:0] right_level[15:0]
//                                       used_ms[6:0]
//   cfg      | in  | cfg_we           | cfg_index[2:0] cfg_wdata[31:0]
//
// A nonzero tick is worked in the shared subtractor at one quotient bit per
// cycle, 17 bits for the stage timer division and 16 for the ramp ratio, with
// the states UPD, CUR and PRV between the two divisions and the multiplier
// states MULL and MULR after them; the ratio division is skipped when the ramp
// is already complete. A zero tick is accepted and gives no result.
// The result sits in an output register; the next tick is accepted while it
// waits, and the sequencer holds at its last step only if the register is
// still full. Reset is synchronous; no clearing pass is needed.
module staged_ramp_setpoint_generator
  import srsg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  srsg_tick_if.sink           tick,
  srsg_level_if.source        level,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  // Configuration registers
  logic [DurW-1:0] stage_duration;
  logic [DurW-1:0] transition_duration;
  logic [TgtW-1:0] tgt0, tgt1, tgt2, tgt3;

  // Block state
  logic [StageW-1:0] stage_index;
  logic [DurW-1:0]   stage_timer;
  logic              cycle_done;

  // Sequencer and datapath registers
  state_t                  state;
  logic [TimeSumW-1:0]     t_sh;
  logic [DurW-1:0]         rem;
  logic [4:0]              cnt;
  logic [1:0]              q_lo;
  logic                    q_hi;
  logic [RatioW-1:0]       ratio;
  logic [UsedW-1:0]        used_q;
  logic [LevelW-1:0]       cur_l, cur_r, prev_l, prev_r;
  logic signed [ProdW-1:0] prod;
  logic [LevelW-1:0]       out_left;

  // Output register
  logic              out_valid;
  logic [LevelW-1:0] out_l, out_r;
  logic [UsedW-1:0]  out_used;

  // Effective durations
  logic [DurW-1:0]     dur, trans, eff;
  logic [ElapsedW-1:0] used;

  assign dur   = (stage_duration == '0) ? DEF_STAGE_MS : stage_duration;
  assign trans = (transition_duration == '0) ? DEF_TRANS_MS : transition_duration;
  assign eff   = (trans < dur) ? trans : dur;
  assign used  = (tick.elapsed_ms > MAX_STEP_MS) ? MAX_STEP_MS : tick.elapsed_ms;

  // Handshakes
  logic tick_acc, fin_load;
  assign tick.ready = (state == ST_IDLE);
  assign tick_acc   = tick.valid && tick.ready;
  assign fin_load   = (state == ST_FIN) && (!out_valid || level.ready);

  assign level.valid       = out_valid;
  assign level.left_level  = out_l;
  assign level.right_level = out_r;
  assign level.used_ms     = out_used;

  // Shared subtract-and-compare unit
  logic [TimeSumW-1:0] sub_a;
  logic [DurW-1:0]     sub_b;
  logic [TimeSumW:0]   sub_diff;
  logic                sub_ge;

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state)
      ST_DIVT: begin
        sub_a = {rem, t_sh[TimeSumW-1]};
        sub_b = dur;
      end
      ST_PRV: begin
        sub_a = {1'b0, stage_timer};
        sub_b = eff;
      end
      ST_DIVR: begin
        sub_a = {rem, 1'b0};
        sub_b = eff;
      end
      default: begin
      end
    endcase
  end

  assign sub_diff = {1'b0, sub_a} - {2'b0, sub_b};
  assign sub_ge   = ~sub_diff[TimeSumW];

  // Target word select: current stage, then the previous one
  logic [StageW-1:0] tgt_idx;
  logic [TgtW-1:0]   tgt_word;

  always_comb begin
    if (state == ST_PRV && (stage_index != '0 || cycle_done)) begin
      tgt_idx = stage_index - StageW'(1);
    end else begin
      tgt_idx = stage_index;
    end
  end

  always_comb begin
    unique case (tgt_idx)
      2'd0:    tgt_word = tgt0;
      2'd1:    tgt_word = tgt1;
      2'd2:    tgt_word = tgt2;
      default: tgt_word = tgt3;
    endcase
  end

  // Shared multiplier: difference times ratio
  logic signed [DiffW-1:0] diff_l, diff_r, mul_a;
  logic signed [ProdW-1:0] mul_p;

  assign diff_l = $signed({1'b0, cur_l}) - $signed({1'b0, prev_l});
  assign diff_r = $signed({1'b0, cur_r}) - $signed({1'b0, prev_r});
  assign mul_a  = (state == ST_MULL) ? diff_l : diff_r;
  assign mul_p  = ProdW'(mul_a * $signed({1'b0, ratio}));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_duration      <= DEF_STAGE_MS;
      transition_duration <= DEF_TRANS_MS;
      tgt0                <= DEF_TGT0;
      tgt1                <= DEF_TGT1;
      tgt2                <= DEF_TGT2;
      tgt3                <= DEF_TGT3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STAGE_DUR: stage_duration      <= cfg_wdata[DurW-1:0];
        REG_TRANS_DUR: transition_duration <= cfg_wdata[DurW-1:0];
        REG_TGT0:      tgt0                <= cfg_wdata;
        REG_TGT1:      tgt1                <= cfg_wdata;
        REG_TGT2:      tgt2                <= cfg_wdata;
        REG_TGT3:      tgt3                <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      stage_index <= '0;
      stage_timer <= '0;
      cycle_done  <= 1'b0;
      cnt         <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          // Take a tick; a zero tick is dropped here
          if (tick_acc && tick.elapsed_ms != '0) begin
            cnt   <= 5'(TimeSumW - 1);
            state <= ST_DIVT;
          end
        end
        ST_DIVT: begin
          // One quotient bit of (timer + used) / duration per cycle
          if (cnt == '0) begin
            state <= ST_UPD;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        ST_UPD: begin
          // Advance the stage by the quotient
          stage_timer <= rem;
          if (q_hi || q_lo != '0) begin
            if (({1'b0, stage_index} + {1'b0, q_lo}) >= 3'd4 || q_hi) begin
              cycle_done <= 1'b1;
            end
            stage_index <= stage_index + q_lo;
          end
          state <= ST_CUR;
        end
        ST_CUR: begin
          state <= ST_PRV;
        end
        ST_PRV: begin
          // Ramp already complete: skip the ratio division
          if (sub_ge) begin
            state <= ST_MULL;
          end else begin
            cnt   <= 5'd15;
            state <= ST_DIVR;
          end
        end
        ST_DIVR: begin
          if (cnt == '0) begin
            state <= ST_MULL;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        ST_MULL: begin
          state <= ST_MULR;
        end
        ST_MULR: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          // Hold until the output register is free
          if (fin_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        t_sh   <= {1'b0, stage_timer} + TimeSumW'(used);
        used_q <= used[UsedW-1:0];
        rem    <= '0;
        q_lo   <= '0;
        q_hi   <= 1'b0;
      end
      ST_DIVT: begin
        rem  <= sub_ge ? sub_diff[DurW-1:0] : sub_a[DurW-1:0];
        t_sh <= {t_sh[TimeSumW-2:0], 1'b0};
        q_lo <= {q_lo[0], sub_ge};
        q_hi <= q_hi | q_lo[1];
      end
      ST_CUR: begin
        cur_l <= clamp_half(tgt_word[TgtW-1:LevelW]);
        cur_r <= clamp_half(tgt_word[LevelW-1:0]);
      end
      ST_PRV: begin
        prev_l <= clamp_half(tgt_word[TgtW-1:LevelW]);
        prev_r <= clamp_half(tgt_word[LevelW-1:0]);
        rem    <= stage_timer;
        ratio  <= sub_ge ? RATIO_ONE : '0;
      end
      ST_DIVR: begin
        rem   <= sub_ge ? sub_diff[DurW-1:0] : sub_a[DurW-1:0];
        ratio <= {ratio[RatioW-2:0], sub_ge};
      end
      ST_MULL: begin
        prod <= mul_p;
      end
      ST_MULR: begin
        out_left <= ramp_level(prev_l, prod);
        prod     <= mul_p;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (level.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_l    <= out_left;
      out_r    <= ramp_level(prev_r, prod);
      out_used <= used_q;
    end
  end

  // Checks
  a_zero_tick_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (tick_acc && tick.elapsed_ms == '0) |=>
      (state == ST_IDLE && $stable(stage_timer) && $stable(stage_index)))
    else $error("zero tick changed the stage state");

  a_tick_starts_division: assert property (@(posedge clk) disable iff (rst)
    (tick_acc && tick.elapsed_ms != '0) |=> (state == ST_DIVT && cnt == 5'(TimeSumW - 1)))
    else $error("nonzero tick did not start the timer division");

  a_remainder_below_duration: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> (rem < dur))
    else $error("stage timer remainder not below stage duration");

  a_ratio_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULL) |-> (ratio <= RATIO_ONE))
    else $error("ramp ratio above one");

  a_finish_loads_output: assert property (@(posedge clk) disable iff (rst)
    fin_load |=> (out_valid && state == ST_IDLE && out_used != '0))
    else $error("finished item not presented");

endmodule
